### hdl/ppbc_pkg.sv
// Shared types, opcodes and helpers for the permutation pad byte cipher.
`default_nettype none

package ppbc_pkg;

   localparam int LANE_BITS  = 8;
   localparam int LANE_IDX_W = 3;
   localparam logic [LANE_IDX_W-1:0] LANE_TOP = LANE_IDX_W'(LANE_BITS - 1);

   // One bit permutation: entry r holds the source lane for lane r.
   typedef logic [LANE_BITS-1:0][LANE_IDX_W-1:0] perm_type;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_BUILD   = 2'd1,
      OP_PROCESS = 2'd2
   } opcode_type;

   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   function automatic perm_type identity_perm();
      perm_type p;
      for (int i = 0; i < LANE_BITS; i++) begin
         p[i] = LANE_IDX_W'(i);
      end
      return p;
   endfunction

endpackage

`default_nettype wire

### hdl/ppbc_permute.sv
// Bit permutation of one byte by a pad entry, forward or transposed.
`default_nettype none

module ppbc_permute
   import ppbc_pkg::*;
(
   input  wire perm_type               perm,
   input  wire logic                   direction,
   input  wire logic [LANE_BITS-1:0]   data_in,
   output logic      [LANE_BITS-1:0]   data_out
);

   always_comb begin
      logic [LANE_IDX_W-1:0] src;
      logic [LANE_IDX_W-1:0] lane;
      data_out = '0;
      for (int r = 0; r < LANE_BITS; r++) begin
         src  = LANE_TOP - perm[r];
         lane = LANE_TOP - LANE_IDX_W'(r);
         if (direction == DIR_ENCRYPT) begin
            data_out[lane] = data_in[src];
         end else begin
            // The transpose scatters each input lane to the lane the entry names.
            data_out[src] = data_in[lane];
         end
      end
   end

endmodule

`default_nettype wire

### hdl/permutation_pad_byte_cipher.sv
// Top level of the permutation pad byte cipher: key stores, pad memory and sequencer.
`default_nettype none

// Channel  Dir  Transfer moves
// req_*    in   one command: key load, pad build or data byte
// rsp_*    out  one permuted data byte for each data byte command
// csr_*    in   direction register (0 encrypt, 1 decrypt)
//
// A key load is taken in the idle state. A data byte goes through the choice
// memory read, the pad memory read, then the output register, which can hold a
// finished byte while the next command is accepted. A pad build walks the swap
// memory one entry a cycle. A stalled output holds a data byte in the pad read
// state. Reset clears the byte position, direction and pad valid bits, so every
// pad entry reads as the identity until a build writes it.

module permutation_pad_byte_cipher
   import ppbc_pkg::*;
#(
   parameter int GATES = 16
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [4:0] key_position, [7:5] swap_index, [11:8] gate_choice, [19:12] data_byte
   input  wire logic [23:0] req_tdata,
   // [1:0] opcode
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] out_byte
   output logic [7:0]       rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   localparam int KEY_SLOTS = GATES + LANE_BITS - 1;
   localparam int KW        = $clog2(KEY_SLOTS);
   localparam int GW        = (GATES > 1) ? $clog2(GATES) : 1;
   localparam logic [GW-1:0] LAST_GATE = GW'(GATES - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_BUILD  = 4'b0010,
      ST_CHOICE = 4'b0100,
      ST_PAD    = 4'b1000
   } state_type;

   function automatic logic [GW-1:0] gate_of(input logic [3:0] c);
      logic [GW-1:0] g;
      g = '0;
      for (int v = 0; v < 16; v++) begin
         if (c == 4'(v)) begin
            g = GW'(v % GATES);
         end
      end
      return g;
   endfunction

   state_type             state_ff, state_in;
   logic                  direction_ff;
   logic [GW-1:0]         byte_pos_ff, byte_pos_in;
   logic [GW-1:0]         gate_ff, gate_in;
   logic [LANE_IDX_W-1:0] step_ff, step_in;
   perm_type              perm_ff, perm_in, perm_swapped;
   logic [7:0]            data_ff;

   logic [LANE_IDX_W-1:0] swap_mem [KEY_SLOTS];
   logic [LANE_IDX_W-1:0] swap_rd_ff;
   logic [KW-1:0]         swap_raddr;
   logic                  swap_rd_en, swap_we;

   logic [3:0]            choice_mem [GATES];
   logic [3:0]            choice_rd_ff;
   logic                  choice_rd_en, choice_we;

   perm_type              pad_mem [GATES];
   perm_type              pad_rd_ff;
   logic [GATES-1:0]      pad_valid_ff;
   logic                  pad_rd_valid_ff;
   logic                  pad_rd_en, pad_wr_en;
   logic [GW-1:0]         gate_sel;

   logic                  req_acc;
   logic [4:0]            key_pos;
   logic                  out_load;
   logic                  rsp_tvalid_ff;
   logic [7:0]            rsp_data_ff;
   logic [7:0]            permuted;
   perm_type              perm_use;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign key_pos    = req_tdata[4:0];
   assign gate_sel   = gate_of(choice_rd_ff);

   // One shuffle step: exchange the lane being finished with the lane read from the key.
   always_comb begin
      perm_swapped          = perm_ff;
      perm_swapped[swap_rd_ff] = perm_ff[step_ff];
      perm_swapped[step_ff]    = perm_ff[swap_rd_ff];
   end

   always_comb begin
      state_in     = state_ff;
      byte_pos_in  = byte_pos_ff;
      gate_in      = gate_ff;
      step_in      = step_ff;
      perm_in      = perm_ff;
      swap_raddr   = KW'(LANE_TOP);
      swap_rd_en   = 1'b0;
      swap_we      = 1'b0;
      choice_rd_en = 1'b0;
      choice_we    = 1'b0;
      pad_rd_en    = 1'b0;
      pad_wr_en    = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_tuser)
                  OP_LOAD: begin
                     swap_we   = (32'(key_pos) < KEY_SLOTS);
                     choice_we = (32'(key_pos) < GATES);
                  end
                  OP_BUILD: begin
                     gate_in    = '0;
                     step_in    = LANE_TOP;
                     perm_in    = identity_perm();
                     swap_rd_en = 1'b1;
                     swap_raddr = KW'(LANE_TOP);
                     state_in   = ST_BUILD;
                  end
                  OP_PROCESS: begin
                     choice_rd_en = 1'b1;
                     if (req_tlast || byte_pos_ff == LAST_GATE) begin
                        byte_pos_in = '0;
                     end else begin
                        byte_pos_in = byte_pos_ff + GW'(1);
                     end
                     state_in = ST_CHOICE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BUILD: begin
            perm_in = perm_swapped;
            if (step_ff == '0) begin
               pad_wr_en = 1'b1;
               perm_in   = identity_perm();
               if (gate_ff == LAST_GATE) begin
                  state_in = ST_IDLE;
               end else begin
                  gate_in    = gate_ff + GW'(1);
                  step_in    = LANE_TOP;
                  swap_rd_en = 1'b1;
                  swap_raddr = KW'(gate_ff) + KW'(LANE_BITS);
               end
            end else begin
               step_in    = step_ff - LANE_IDX_W'(1);
               swap_rd_en = 1'b1;
               swap_raddr = KW'(gate_ff) + KW'(step_ff - LANE_IDX_W'(1));
            end
         end
         ST_CHOICE: begin
            pad_rd_en = 1'b1;
            state_in  = ST_PAD;
         end
         ST_PAD: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         byte_pos_ff   <= '0;
         direction_ff  <= DIR_ENCRYPT;
         rsp_tvalid_ff <= 1'b0;
         pad_valid_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         byte_pos_ff <= byte_pos_in;
         if (csr_wr_en) begin
            direction_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (pad_wr_en) begin
            pad_valid_ff[gate_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      gate_ff <= gate_in;
      step_ff <= step_in;
      perm_ff <= perm_in;
      if (req_acc) begin
         data_ff <= req_tdata[19:12];
      end
      if (out_load) begin
         rsp_data_ff <= permuted;
      end
   end

   // Key stores. Only one command is in flight, so a write never meets a read
   // of the same entry.
   always_ff @(posedge clock) begin
      if (swap_we) begin
         swap_mem[KW'(key_pos)] <= req_tdata[7:5];
      end
      if (swap_rd_en) begin
         swap_rd_ff <= swap_mem[swap_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (choice_we) begin
         choice_mem[GW'(key_pos)] <= req_tdata[11:8];
      end
      if (choice_rd_en) begin
         choice_rd_ff <= choice_mem[byte_pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (pad_wr_en) begin
         pad_mem[gate_ff] <= perm_swapped;
      end
      if (pad_rd_en) begin
         pad_rd_ff       <= pad_mem[gate_sel];
         pad_rd_valid_ff <= pad_valid_ff[gate_sel];
      end
   end

   assign perm_use = pad_rd_valid_ff ? pad_rd_ff : identity_perm();

   ppbc_permute u_permute (
      .perm      (perm_use),
      .direction (direction_ff),
      .data_in   (data_ff),
      .data_out  (permuted)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### dv/permutation_pad_byte_cipher_tb.sv
// Self-checking testbench for the permutation pad byte cipher: directed tests, then random traffic.
module permutation_pad_byte_cipher_tb;
   import ppbc_pkg::*;

   localparam int GATES        = 16;
   localparam int KEY_SLOTS    = GATES + LANE_BITS - 1;
   localparam int DRAIN_CYCLES = 8 * GATES + 20;
   localparam int IDLE_PCT     = 12;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // [4:0] key_position, [7:5] swap_index, [11:8] gate_choice, [19:12] data_byte
   logic [23:0] req_tdata   = '0;
   // [1:0] opcode
   logic [1:0]  req_tuser   = '0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // [7:0] out_byte
   logic [7:0]  rsp_tdata;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   // Shadow copy of the cipher state.
   logic [2:0]  swap_mem   [KEY_SLOTS];
   logic [3:0]  choice_mem [GATES];
   logic [2:0]  pad_map    [GATES][LANE_BITS];
   logic [3:0]  byte_pos   = '0;
   logic        dir_q      = DIR_ENCRYPT;

   logic [7:0]  expected_bytes [$];
   int          mismatch_count = 0;
   bit          no_gaps        = 1'b0;

   permutation_pad_byte_cipher #(.GATES(GATES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_rsp
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected out_byte 0x%02h", rsp_tdata));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want) begin
               report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h", rsp_tdata, want));
            end
         end
      end
   end

   function automatic void rebuild_pad();
      logic [2:0] perm [LANE_BITS];
      logic [2:0] k;
      logic [2:0] t;
      for (int g = 0; g < GATES; g++) begin
         for (int i = 0; i < LANE_BITS; i++) begin
            perm[i] = 3'(i);
         end
         for (int i = LANE_BITS - 1; i >= 0; i--) begin
            k = swap_mem[g + i];
            t = perm[k];
            perm[k] = perm[i];
            perm[i] = t;
         end
         pad_map[g] = perm;
      end
   endfunction

   // Encrypt takes output bit 7-r from input bit 7-S[r]; decrypt is the transpose.
   function automatic logic [7:0] predict_cipher_byte(logic [7:0] din);
      logic [7:0] dout;
      logic [3:0] gate;
      logic [2:0] c;
      dout = '0;
      gate = choice_mem[byte_pos];
      for (int r = 0; r < LANE_BITS; r++) begin
         c = pad_map[gate][r];
         if (dir_q == DIR_ENCRYPT) begin
            dout[7 - r] = din[7 - c];
         end else begin
            dout[7 - c] = din[7 - r];
         end
      end
      return dout;
   endfunction

   function automatic void apply_cmd(logic [1:0] op, logic [4:0] pos, logic [2:0] swp,
                                     logic [3:0] gate, logic [7:0] data, logic last);
      case (op)
         OP_LOAD: begin
            if (pos < KEY_SLOTS) swap_mem[pos] = swp;
            if (pos < GATES) choice_mem[pos] = gate;
         end
         OP_BUILD: rebuild_pad();
         OP_PROCESS: begin
            expected_bytes.push_back(predict_cipher_byte(data));
            byte_pos = last ? 4'd0 : byte_pos + 4'd1;
         end
         default: ;
      endcase
   endfunction

   task automatic send_cmd(input logic [1:0] op, input logic [4:0] pos, input logic [2:0] swp,
                           input logic [3:0] gate, input logic [7:0] data, input logic last);
      while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, data, gate, swp, pos};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      apply_cmd(op, pos, swp, gate, data, last);
   endtask

   task automatic send_byte(input logic [7:0] data, input logic last);
      send_cmd(OP_PROCESS, 5'($urandom), 3'($urandom), 4'($urandom), data, last);
   endtask

   // A build can run with no result in flight, so allow for it after the last byte.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_direction(input logic value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      dir_q = value;
   endtask

   task automatic load_full_key();
      for (int p = 0; p < KEY_SLOTS; p++) begin
         send_cmd(OP_LOAD, 5'(p), 3'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
      end
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h01 << $urandom_range(7);
         default: return 8'($urandom);
      endcase
   endfunction

   // Every key slot gets written first, so no later read ever hits an unwritten entry.
   task automatic test_key_load();
      for (int p = 0; p < KEY_SLOTS; p++) begin
         send_cmd(OP_LOAD, 5'(p), 3'(7 - (p % 8)), 4'(15 - p), 8'(p), p[0]);
      end
      // Positions past the key store and the reserved opcode must leave everything alone.
      send_cmd(OP_LOAD, 5'd23, 3'd7, 4'd15, 8'hFF, 1'b1);
      send_cmd(OP_LOAD, 5'd31, 3'd7, 4'd15, 8'hFF, 1'b0);
      send_cmd(OP_RESERVED, 5'd31, 3'd7, 4'd15, 8'hFF, 1'b1);
   endtask

   task automatic test_identity_pad();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   task automatic test_build_and_encrypt();
      send_cmd(OP_BUILD, 5'd0, 3'd0, 4'd0, 8'h00, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h3C, 1'b1);
   endtask

   task automatic test_decrypt();
      set_direction(DIR_DECRYPT);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b1);
      set_direction(DIR_ENCRYPT);
   endtask

   // Mostly whole messages, with occasional rekeys and some noise in between.
   task automatic test_random_traffic(input int num_items, input logic dir, input bit steady);
      int sent;
      int roll;
      int len;
      set_direction(dir);
      no_gaps = steady;
      sent = 0;
      while (sent < num_items) begin
         roll = $urandom_range(99);
         if (roll < 5) begin
            load_full_key();
            send_cmd(OP_BUILD, 5'($urandom), 3'($urandom), 4'($urandom), 8'($urandom),
                     1'($urandom));
            sent += KEY_SLOTS + 1;
         end else if (roll < 9) begin
            send_cmd(OP_LOAD, 5'($urandom_range(KEY_SLOTS - 1)), 3'($urandom), 4'($urandom),
                     8'($urandom), 1'($urandom));
            sent++;
         end else if (roll < 11) begin
            send_cmd(OP_LOAD, 5'($urandom_range(31, KEY_SLOTS)), 3'($urandom), 4'($urandom),
                     8'($urandom), 1'($urandom));
            sent++;
         end else if (roll < 13) begin
            send_cmd(OP_RESERVED, 5'($urandom), 3'($urandom), 4'($urandom), 8'($urandom),
                     1'($urandom));
            sent++;
         end else if (roll < 14) begin
            send_cmd(OP_BUILD, 5'($urandom), 3'($urandom), 4'($urandom), 8'($urandom),
                     1'($urandom));
            sent++;
         end else begin
            // A few messages run on without a final byte so the position wraps.
            len = $urandom_range(1, 24);
            for (int n = 0; n < len; n++) begin
               send_byte(pick_byte(), (n == len - 1) && ($urandom_range(9) != 0));
            end
            sent += len;
         end
      end
      wait_idle();
      no_gaps = 1'b0;
   endtask

   initial begin
      for (int g = 0; g < GATES; g++) begin
         for (int r = 0; r < LANE_BITS; r++) begin
            pad_map[g][r] = 3'(r);
         end
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_key_load();
      test_identity_pad();
      test_build_and_encrypt();
      test_decrypt();
      test_random_traffic(470, DIR_DECRYPT, 1'b0);
      test_random_traffic(470, DIR_ENCRYPT, 1'b1);
      test_random_traffic(470, DIR_DECRYPT, 1'b0);
      test_random_traffic(470, DIR_ENCRYPT, 1'b0);
      wait_idle();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
